### src/itr_pkg.sv
package itr_pkg;

    localparam int RING_MAX  = 1024;
    localparam int SLOT_W    = 10;
    localparam int LOG2_W    = 4;
    localparam int DEPTH_DEF = 1024;
    localparam int ENTRY_W   = 128;

    localparam logic [LOG2_W-1:0] LOG2_MAX = LOG2_W'(10);

    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_COMMIT     = 3'd1,
        CMD_NULL       = 3'd2,
        CMD_CHECKPOINT = 3'd3,
        CMD_ADVANCE    = 3'd4,
        CMD_FETCH      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [63:0] time_in;
        logic signed [31:0] index_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] time_out;
        logic signed [31:0] index_out;
        logic [SLOT_W-1:0]  slot_out;
        logic               is_null;
        logic               walk_capped;
        logic signed [31:0] start_index;
        logic signed [31:0] end_index;
        logic signed [63:0] start_time;
        logic signed [63:0] end_time;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic eval;
        logic load;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_is_read;
        logic walk_done;
        logic out_free;
    } t_ctl_stat;

endpackage

### src/itr_ram.sv
module itr_ram #(
    parameter int WIDTH = 128,
    parameter int WORDS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(WORDS)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(WORDS)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/itr_ctrl.sv
module itr_ctrl
    import itr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_ctl,
    output logic      o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_is_read ? ST_WAIT : ST_FINISH;
                end
            end
            ST_WAIT: begin
                if (i_stat.walk_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = !i_rst_n;
                o_ctl.accept = i_in_valid && i_rst_n;
            end
            ST_WAIT: begin
                o_ctl.eval = 1'b1;
            end
            ST_FINISH: begin
                o_ctl.load = i_stat.out_free;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> r_state == ST_IDLE)
        else $error("result load did not return to idle");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && !i_stat.out_free) |=> r_state == ST_FINISH)
        else $error("finished result dropped while output busy");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.accept && (o_ctl.eval || o_ctl.load)))
        else $error("accept overlaps with work on a prior item");
`endif

endmodule

### src/itr_dp.sv
module itr_dp
    import itr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_ctl,
    output t_ctl_stat         o_stat,
    input  t_in_beat          i_in_beat,
    input  logic              i_cfg_we,
    input  logic [LOG2_W-1:0] i_cfg_wdata,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_beat         o_out_beat
);

    localparam int STEP_W = $clog2(DEPTH + 1);

    logic [LOG2_W-1:0]  r_log2;
    logic [2:0]         r_cmd;
    logic signed [63:0] r_time;
    logic [31:0]        r_idx;
    logic [STEP_W-1:0]  r_steps;
    logic [31:0]        r_head;
    logic [30:0]        r_count;
    logic [63:0]        r_rstart;
    logic [63:0]        r_rend;
    logic [63:0]        r_time_out;
    logic               r_is_null;
    logic               r_capped;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic [LOG2_W-1:0]  w_log2;
    logic [SLOT_W:0]    w_size;
    logic [SLOT_W-1:0]  w_mask;
    logic [30:0]        w_cnt;
    logic [31:0]        w_head_inc;
    logic [31:0]        w_idx_inc;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_re;
    logic [SLOT_W-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic signed [63:0] w_ent_start;
    logic signed [63:0] w_ent_end;
    logic               w_le_start;
    logic               w_end_lt;
    logic               w_done;
    logic               w_out_free;

    assign w_log2     = (r_log2 > LOG2_MAX) ? LOG2_MAX : r_log2;
    assign w_size     = (SLOT_W + 1)'(1) << w_log2;
    assign w_mask     = SLOT_W'(w_size - (SLOT_W + 1)'(1));
    assign w_cnt      = (r_count < 31'(w_size)) ? r_count : 31'(w_size);
    assign w_head_inc = r_head + 32'd1;
    assign w_idx_inc  = r_idx + 32'd1;

    assign w_ent_start = $signed(w_rdata[ENTRY_W-1:64]);
    assign w_ent_end   = $signed(w_rdata[63:0]);
    assign w_le_start  = r_time <= w_ent_start;
    assign w_end_lt    = w_ent_end < r_time;
    assign w_done      = (r_cmd != CMD_ADVANCE) || !w_end_lt
                         || (r_steps == STEP_W'(DEPTH));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // entries hold {start, end}; a commit stores {previous region end, time_in}
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_head_inc[SLOT_W-1:0] & w_mask;
        w_wdata = {i_in_beat.time_in, i_in_beat.time_in};
        if (i_ctl.accept) begin
            case (i_in_beat.cmd)
                CMD_INIT: begin
                    w_we    = 1'b1;
                    w_waddr = '0;
                end
                CMD_COMMIT: begin
                    w_we    = 1'b1;
                    w_wdata = {r_rend, i_in_beat.time_in};
                end
                CMD_NULL: begin
                    w_we = 1'b1;
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = w_idx_inc[SLOT_W-1:0] & w_mask;
        if (i_ctl.accept) begin
            w_re    = 1'b1;
            w_raddr = i_in_beat.index_in[SLOT_W-1:0] & w_mask;
        end else if (i_ctl.eval && !w_done) begin
            w_re = 1'b1;
        end
    end

    itr_ram #(
        .WIDTH (ENTRY_W),
        .WORDS (RING_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2   <= LOG2_MAX;
            r_head   <= '1;
            r_count  <= '0;
            r_rstart <= '0;
            r_rend   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
            if (i_ctl.accept) begin
                case (i_in_beat.cmd)
                    CMD_INIT: begin
                        r_rstart <= i_in_beat.time_in;
                        r_rend   <= i_in_beat.time_in;
                        r_head   <= '1;
                        r_count  <= '0;
                    end
                    CMD_COMMIT: begin
                        r_rend <= i_in_beat.time_in;
                        r_head <= w_head_inc;
                        if (r_count != '1) begin
                            r_count <= r_count + 31'd1;
                        end
                    end
                    CMD_NULL: begin
                        r_rend <= i_in_beat.time_in;
                    end
                    default: r_head <= r_head;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd      <= i_in_beat.cmd;
            r_time     <= i_in_beat.time_in;
            r_idx      <= i_in_beat.index_in;
            r_steps    <= '0;
            r_time_out <= '0;
            r_is_null  <= 1'b0;
            r_capped   <= 1'b0;
        end else if (i_ctl.eval) begin
            if (w_done) begin
                case (r_cmd)
                    CMD_CHECKPOINT: r_time_out <= w_le_start ? w_ent_start : w_ent_end;
                    CMD_FETCH:      r_is_null  <= w_le_start;
                    CMD_ADVANCE:    r_capped   <= w_end_lt;
                    default:        r_capped   <= 1'b0;
                endcase
            end else begin
                r_idx   <= w_idx_inc;
                r_steps <= r_steps + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_out.time_out    <= r_time_out;
            r_out.index_out   <= r_idx;
            r_out.slot_out    <= r_idx[SLOT_W-1:0] & w_mask;
            r_out.is_null     <= r_is_null;
            r_out.walk_capped <= r_capped;
            r_out.start_index <= r_head - 32'(w_cnt) + 32'd1;
            r_out.end_index   <= r_head;
            r_out.start_time  <= r_rstart;
            r_out.end_time    <= r_rend;
        end
    end

    assign o_stat.in_is_read = (i_in_beat.cmd == CMD_CHECKPOINT)
                               || (i_in_beat.cmd == CMD_ADVANCE)
                               || (i_in_beat.cmd == CMD_FETCH);
    assign o_stat.walk_done  = w_done;
    assign o_stat.out_free   = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out;

`ifndef ASSERT_OFF
    a_steps_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.eval |-> r_steps <= STEP_W'(DEPTH))
        else $error("walk exceeded step cap");

    a_lookup_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.eval && r_cmd != CMD_ADVANCE) |-> w_done)
        else $error("checkpoint or fetch took more than one read");

    a_init_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && i_in_beat.cmd == CMD_INIT) |=> (r_head == '1 && r_count == '0))
        else $error("init did not clear head and count");
`endif

endmodule

### src/interval_timeline_ring.sv
// Ring of time intervals with region start/end times and a head index.
// Input channel: i_in_valid / o_in_stall carry one beat {cmd, time_in,
// index_in}; a beat is taken at a clock edge with i_in_valid high and
// o_in_stall low. Output channel: o_out_valid / i_out_stall carry one result
// beat per input beat, in order.
// Config: i_cfg_we writes ring_size_log2 (values above 10 act as 10); write
// only while the block is idle.
// Flow: init, commit and null go from accept to the finish state, which
// loads the result register; checkpoint, fetch and advance first pass a
// wait state where advance walks N entries (N at most DEPTH); one ring read
// per cycle through the registered RAM port sets the walk rate. A new beat
// is taken only after the result of the last one has been loaded.
// The result register lets a new beat be taken while a result waits; a
// stalled output holds its beat, and a finished item waits until the output
// register frees up, stalling the input meanwhile.
// Reset (synchronous, i_rst_n low): head -1, count 0, region times 0, ring
// size 10, output empty, input stalled. Ring contents are not cleared.
module interval_timeline_ring
    import itr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_beat,
    input  logic              i_cfg_we,
    input  logic [LOG2_W-1:0] i_cfg_wdata
);

    t_ctl_cmd  w_ctl;
    t_ctl_stat w_stat;

    itr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_in_stall (o_in_stall)
    );

    itr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_stat      (w_stat),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule
